// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the engine's RTL files.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with the active-low reset as disable condition.
`define NNTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== hdl/nntt_pkg.sv =====
// Shared types, constants and modular helper functions for the NTT engine.
// No dependencies; imported by every module of the engine.
`default_nettype none

package nntt_pkg;

    localparam int MAX_DEGREE = 1024;
    localparam int LOG_MAX    = 10;
    localparam int CW         = 62;
    localparam int IW         = 10;
    localparam int CNTW       = $clog2(CW + 1);

    typedef logic [CW-1:0] t_coeff;
    typedef logic [IW-1:0] t_idx;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FWD   = 2'd1,
        OP_INV   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;

    localparam logic [2:0] REG_MODULUS = 3'd0;
    localparam logic [2:0] REG_LOG     = 3'd1;
    localparam logic [2:0] REG_PSI     = 3'd2;
    localparam logic [2:0] REG_PSI_INV = 3'd3;
    localparam logic [2:0] REG_N_INV   = 3'd4;

    typedef struct packed {
        logic   start;
        t_coeff a;
        t_coeff b;
        t_coeff q;
    } t_mul_req;

    typedef struct packed {
        logic   done;
        t_coeff res;
    } t_mul_rsp;

    function automatic t_coeff add_mod(input t_coeff a, input t_coeff b, input t_coeff q);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, q}) ? CW'(s - {1'b0, q}) : CW'(s);
    endfunction

    function automatic t_coeff sub_mod(input t_coeff a, input t_coeff b, input t_coeff q);
        return (a >= b) ? (a - b) : (a + (q - b));
    endfunction

    function automatic t_idx bit_rev(input t_idx v);
        t_idx r;
        for (int k = 0; k < IW; k++) begin
            r[IW-1-k] = v[k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nntt_mulmod.sv =====
// Bit-serial modular multiplier: one shift-and-add step per cycle.
// Depends on nntt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nntt_mulmod import nntt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    t_coeff          r_acc;
    t_coeff          r_a;
    t_coeff          r_b;
    t_coeff          r_q;
    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    t_coeff          dbl;
    t_coeff          step;

    always_comb begin
        dbl  = add_mod(r_acc, r_acc, r_q);
        step = r_b[CW-1] ? add_mod(dbl, r_a, r_q) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_acc <= '0;
                r_a   <= i_req.a;
                r_b   <= i_req.b;
                r_q   <= i_req.q;
                r_cnt <= CNTW'(CW);
            end else if (r_cnt != '0) begin
                r_acc <= step;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

    `NNTT_ASSERT(a_done_single, i_clk, i_rst_n, r_done |=> !r_done, "done held for two cycles")
    `NNTT_ASSERT(a_start_load, i_clk, i_rst_n, i_req.start |=> (r_cnt == CNTW'(CW)), "no load")

endmodule

`default_nettype wire

// ===== hdl/negacyclic_ntt_engine_core.sv =====
// A write reports on o_done in the cycle after it is accepted, a read after a pass through S_READ.
// A transform first reduces the stored coefficients and builds the twiddle table, then runs
// (n/2)*log2(n) butterflies on the serial multiplier; butterflies of the inverse's first
// stage also scale both outputs by n_inv. The receiver cannot stall.
// Synchronous active-low reset clears control, status and the config registers; the stores keep contents.
`default_nettype none
`include "assert_macros.svh"

module negacyclic_ntt_engine_core import nntt_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_op,
    input  wire logic [IW-1:0] i_index,
    input  wire logic [CW-1:0] i_coeff_in,
    output logic               o_done,
    output logic [CW-1:0]      o_coeff_out,
    output logic [1:0]         o_status,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [CW-1:0] i_cfg_data
);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_READ    = 22'h000002,
        S_RED_RD  = 22'h000004,
        S_RED_MUL = 22'h000008,
        S_RED_W   = 22'h000010,
        S_ROOT    = 22'h000020,
        S_ROOT_W  = 22'h000040,
        S_NI      = 22'h000080,
        S_NI_W    = 22'h000100,
        S_FILL    = 22'h000200,
        S_FILL_W  = 22'h000400,
        S_BF_RD   = 22'h000800,
        S_BF_RD2  = 22'h001000,
        S_BF_RD3  = 22'h002000,
        S_BF_MUL1 = 22'h004000,
        S_BF_W1   = 22'h008000,
        S_BF_MUL2 = 22'h010000,
        S_BF_W2   = 22'h020000,
        S_BF_MUL3 = 22'h040000,
        S_BF_W3   = 22'h080000,
        S_WR1     = 22'h100000,
        S_WR2     = 22'h200000
    } t_state;

    t_state      r_state;
    t_idx        r_k;
    logic [3:0]  r_lt;
    logic        r_inv;
    t_coeff      r_a, r_b, r_w, r_x, r_y, r_p, r_pr, r_ni;
    logic        r_done;
    t_coeff      r_cout;
    logic [1:0]  r_status;
    t_coeff      r_modulus, r_psi, r_psi_inv, r_n_inv;
    logic [3:0]  r_log;

    t_coeff      r_cmem [MAX_DEGREE];
    t_coeff      r_tmem [MAX_DEGREE];
    t_coeff      r_crd;
    t_coeff      r_trd;

    t_coeff      q_eff;
    logic [3:0]  lg;
    logic [IW:0] n_full;
    t_idx        n_m1, half_m1;
    t_idx        bit_lt, mask, hi, j, jt, tw_idx;
    logic        last_stage;
    logic        accept, idx_bad, val_bad;
    t_idx        c_raddr, c_waddr, t_waddr;
    logic        c_we, t_we;
    t_coeff      c_wdata;
    t_mul_req    mul_req;
    t_mul_rsp    mul_rsp;

    nntt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_comb begin
        q_eff = (r_modulus < CW'(3)) ? CW'(3) : r_modulus;
        if (r_log == 4'd0) begin
            lg = 4'd1;
        end else if (r_log > 4'(LOG_MAX)) begin
            lg = 4'(LOG_MAX);
        end else begin
            lg = r_log;
        end
        n_full     = (IW+1)'(1) << lg;
        n_m1       = IW'(n_full - 1'b1);
        half_m1    = IW'((n_full >> 1) - 1'b1);
        bit_lt     = IW'(1) << r_lt;
        mask       = bit_lt - 1'b1;
        hi         = r_k >> r_lt;
        j          = ((hi << r_lt) << 1) | (r_k & mask);
        jt         = j | bit_lt;
        tw_idx     = (IW'(1) << (lg - 4'd1 - r_lt)) + hi;
        last_stage = r_inv ? (r_lt == lg - 4'd1) : (r_lt == 4'd0);
        accept     = start && (r_state == S_IDLE);
        idx_bad    = i_index > n_m1;
        val_bad    = i_coeff_in >= q_eff;
    end

    always_comb begin
        case (r_state)
            S_IDLE:   c_raddr = i_index;
            S_RED_RD: c_raddr = r_k;
            S_BF_RD:  c_raddr = j;
            S_BF_RD2: c_raddr = jt;
            default:  c_raddr = r_k;
        endcase
        c_we    = 1'b0;
        c_waddr = r_k;
        c_wdata = mul_rsp.res;
        case (r_state)
            S_IDLE: begin
                c_we    = accept && (t_op'(i_op) == OP_WRITE) && !idx_bad && !val_bad;
                c_waddr = i_index;
                c_wdata = i_coeff_in;
            end
            S_RED_W: begin
                c_we = mul_rsp.done;
            end
            S_WR1: begin
                c_we    = 1'b1;
                c_waddr = j;
                c_wdata = r_x;
            end
            S_WR2: begin
                c_we    = 1'b1;
                c_waddr = jt;
                c_wdata = r_y;
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
        t_we    = (r_state == S_FILL);
        t_waddr = bit_rev(r_k) >> (4'(LOG_MAX) - lg);
    end

    always_comb begin
        mul_req.q     = q_eff;
        mul_req.start = 1'b0;
        mul_req.a     = CW'(1);
        mul_req.b     = r_crd;
        case (r_state)
            S_RED_MUL: begin
                mul_req.start = 1'b1;
            end
            S_ROOT: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_inv ? r_psi_inv : r_psi;
            end
            S_NI: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_n_inv;
            end
            S_FILL: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_p;
                mul_req.b     = r_pr;
            end
            S_BF_MUL1: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_w;
                mul_req.b     = r_inv ? sub_mod(r_a, r_b, q_eff) : r_b;
            end
            S_BF_MUL2: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_ni;
                mul_req.b     = r_x;
            end
            S_BF_MUL3: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_ni;
                mul_req.b     = r_y;
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[c_waddr] <= c_wdata;
        end
        r_crd <= r_cmem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= r_p;
        end
        r_trd <= r_tmem[tw_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_k       <= '0;
            r_lt      <= '0;
            r_inv     <= 1'b0;
            r_cout    <= '0;
            r_status  <= ST_OK;
            r_modulus <= CW'(3);
            r_log     <= 4'(LOG_MAX);
            r_psi     <= CW'(1);
            r_psi_inv <= CW'(1);
            r_n_inv   <= CW'(1);
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODULUS: r_modulus <= i_cfg_data;
                    REG_LOG:     r_log     <= i_cfg_data[3:0];
                    REG_PSI:     r_psi     <= i_cfg_data;
                    REG_PSI_INV: r_psi_inv <= i_cfg_data;
                    REG_N_INV:   r_n_inv   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (t_op'(i_op))
                            OP_WRITE: begin
                                r_done   <= 1'b1;
                                r_cout   <= '0;
                                r_status <= idx_bad ? ST_INDEX : (val_bad ? ST_RANGE : ST_OK);
                            end
                            OP_READ: begin
                                r_status <= idx_bad ? ST_INDEX : ST_OK;
                                r_state  <= S_READ;
                            end
                            OP_FWD, OP_INV: begin
                                r_inv   <= (t_op'(i_op) == OP_INV);
                                r_k     <= '0;
                                r_state <= S_RED_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_cout  <= (r_status == ST_OK) ? r_crd : '0;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_RED_RD:  r_state <= S_RED_MUL;
                S_RED_MUL: r_state <= S_RED_W;
                S_RED_W: begin
                    if (mul_rsp.done) begin
                        if (r_k == n_m1) begin
                            r_state <= S_ROOT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RED_RD;
                        end
                    end
                end
                S_ROOT: r_state <= S_ROOT_W;
                S_ROOT_W: begin
                    if (mul_rsp.done) begin
                        r_pr    <= mul_rsp.res;
                        r_state <= S_NI;
                    end
                end
                S_NI: r_state <= S_NI_W;
                S_NI_W: begin
                    if (mul_rsp.done) begin
                        r_ni    <= mul_rsp.res;
                        r_p     <= CW'(1);
                        r_k     <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: r_state <= S_FILL_W;
                S_FILL_W: begin
                    if (mul_rsp.done) begin
                        r_p <= mul_rsp.res;
                        if (r_k == n_m1) begin
                            r_k     <= '0;
                            r_lt    <= r_inv ? 4'd0 : (lg - 4'd1);
                            r_state <= S_BF_RD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_FILL;
                        end
                    end
                end
                S_BF_RD: r_state <= S_BF_RD2;
                S_BF_RD2: begin
                    r_a     <= r_crd;
                    r_w     <= r_trd;
                    r_state <= S_BF_RD3;
                end
                S_BF_RD3: begin
                    r_b     <= r_crd;
                    r_state <= S_BF_MUL1;
                end
                S_BF_MUL1: begin
                    if (r_inv) begin
                        r_x <= add_mod(r_a, r_b, q_eff);
                    end
                    r_state <= S_BF_W1;
                end
                S_BF_W1: begin
                    if (mul_rsp.done) begin
                        if (!r_inv) begin
                            r_x     <= add_mod(r_a, mul_rsp.res, q_eff);
                            r_y     <= sub_mod(r_a, mul_rsp.res, q_eff);
                            r_state <= S_WR1;
                        end else begin
                            r_y     <= mul_rsp.res;
                            r_state <= (r_lt == 4'd0) ? S_BF_MUL2 : S_WR1;
                        end
                    end
                end
                S_BF_MUL2: r_state <= S_BF_W2;
                S_BF_W2: begin
                    if (mul_rsp.done) begin
                        r_x     <= mul_rsp.res;
                        r_state <= S_BF_MUL3;
                    end
                end
                S_BF_MUL3: r_state <= S_BF_W3;
                S_BF_W3: begin
                    if (mul_rsp.done) begin
                        r_y     <= mul_rsp.res;
                        r_state <= S_WR1;
                    end
                end
                S_WR1: r_state <= S_WR2;
                S_WR2: begin
                    if (r_k == half_m1) begin
                        r_k <= '0;
                        if (last_stage) begin
                            r_done   <= 1'b1;
                            r_cout   <= '0;
                            r_status <= ST_OK;
                            r_state  <= S_IDLE;
                        end else begin
                            r_lt    <= r_inv ? (r_lt + 4'd1) : (r_lt - 4'd1);
                            r_state <= S_BF_RD;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_BF_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_coeff_out = r_cout;
    assign o_status    = r_status;

    `NNTT_ASSERT(a_status_code, i_clk, i_rst_n,
        o_done |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_INDEX),
        "bad status code")
    `NNTT_ASSERT(a_refused_zero, i_clk, i_rst_n,
        (o_done && (o_status != ST_OK)) |-> (o_coeff_out == '0),
        "refused request returned data")

endmodule

`default_nettype wire

// ===== tb/negacyclic_ntt_engine_core_test.sv =====
// Self-checking testbench for negacyclic_ntt_engine_core: coefficient writes and reads,
// and forward and inverse transforms, predicted by a scoreboard class.
// Depends on nntt_pkg and the engine RTL.
`timescale 1ns / 100ps

module negacyclic_ntt_engine_core_test;
    import nntt_pkg::*;

    class ntt_scoreboard;
        logic [CW-1:0] modulus, psi, psi_inv, n_inv;
        logic [3:0]    log_degree;
        logic [CW-1:0] store [MAX_DEGREE];
        logic [CW-1:0] exp_coeff [$];
        logic [1:0]    exp_status [$];
        int            errors;
        int            checked;
        int            transforms;

        function new();
            modulus = 3; log_degree = 10; psi = 1; psi_inv = 1; n_inv = 1;
            errors = 0; checked = 0; transforms = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [CW-1:0] data);
            case (idx)
                REG_MODULUS: modulus = data;
                REG_LOG:     log_degree = data[3:0];
                REG_PSI:     psi = data;
                REG_PSI_INV: psi_inv = data;
                REG_N_INV:   n_inv = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] eff_q();
            return (modulus < 3) ? 64'd3 : {2'b0, modulus};
        endfunction

        function int eff_log();
            if (log_degree < 1) return 1;
            if (log_degree > LOG_MAX) return LOG_MAX;
            return log_degree;
        endfunction

        function logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] q);
            logic [63:0] s;
            s = a + b;
            return (s >= q) ? s - q : s;
        endfunction

        function logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b, logic [63:0] q);
            return (a >= b) ? a - b : a + (q - b);
        endfunction

        function logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] q);
            logic [127:0] p;
            p = {64'b0, a} * {64'b0, b};
            return 64'(p % {64'b0, q});
        endfunction

        function int rev_bits(int v, int bits);
            int r;
            r = 0;
            for (int k = 0; k < bits; k++) r |= ((v >> k) & 1) << (bits - 1 - k);
            return r;
        endfunction

        function void build_powers(ref logic [63:0] tab [MAX_DEGREE], input logic [63:0] root,
                                   input int lg, input logic [63:0] q);
            logic [63:0] p;
            p = 1;
            for (int i = 0; i < (1 << lg); i++) begin
                tab[rev_bits(i, lg)] = p;
                p = mod_mul(p, root, q);
            end
        endfunction

        function void run_transform(bit inverse);
            logic [63:0] q, w, a, b, ni;
            logic [63:0] tw [MAX_DEGREE];
            int lg, n, t, base;
            q = eff_q(); lg = eff_log(); n = 1 << lg;
            for (int i = 0; i < n; i++) store[i] = CW'({2'b0, store[i]} % q);
            build_powers(tw, (inverse ? {2'b0, psi_inv} : {2'b0, psi}) % q, lg, q);
            if (!inverse) begin
                t = n >> 1;
                for (int m = 1; m < n; m <<= 1) begin
                    for (int i = 0; i < m; i++) begin
                        w = tw[m + i]; base = 2 * i * t;
                        for (int j = base; j < base + t; j++) begin
                            a = store[j];
                            b = mod_mul(store[j + t], w, q);
                            store[j] = CW'(mod_add(a, b, q));
                            store[j + t] = CW'(mod_sub(a, b, q));
                        end
                    end
                    t >>= 1;
                end
            end else begin
                ni = {2'b0, n_inv} % q;
                for (int i = 0; i < n; i += 2) begin
                    w = tw[(n >> 1) + (i >> 1)];
                    a = store[i]; b = store[i + 1];
                    store[i] = CW'(mod_mul(mod_add(a, b, q), ni, q));
                    store[i + 1] = CW'(mod_mul(mod_mul(mod_sub(a, b, q), w, q), ni, q));
                end
                t = 2;
                for (int m = n >> 2; m >= 1; m >>= 1) begin
                    for (int i = 0; i < m; i++) begin
                        w = tw[m + i]; base = 2 * i * t;
                        for (int j = base; j < base + t; j++) begin
                            a = store[j]; b = store[j + t];
                            store[j] = CW'(mod_add(a, b, q));
                            store[j + t] = CW'(mod_mul(mod_sub(a, b, q), w, q));
                        end
                    end
                    t <<= 1;
                end
            end
        endfunction

        function void note_request(t_op op, t_idx idx, logic [CW-1:0] val);
            logic [CW-1:0] cout;
            logic [1:0]    st;
            int            n;
            n = 1 << eff_log();
            cout = '0; st = ST_OK;
            case (op)
                OP_WRITE: begin
                    if (idx >= n) st = ST_INDEX;
                    else if ({2'b0, val} >= eff_q()) st = ST_RANGE;
                    else store[idx] = val;
                end
                OP_FWD: begin run_transform(0); transforms++; end
                OP_INV: begin run_transform(1); transforms++; end
                default: begin
                    if (idx >= n) st = ST_INDEX;
                    else cout = store[idx];
                end
            endcase
            exp_coeff.push_back(cout);
            exp_status.push_back(st);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [CW-1:0] coeff, logic [1:0] status);
            logic [CW-1:0] want_c;
            logic [1:0]    want_s;
            checked++;
            if (exp_coeff.size() == 0) begin
                report_mismatch("unexpected result", {2'b0, coeff}, 0);
            end else begin
                want_c = exp_coeff.pop_front();
                want_s = exp_status.pop_front();
                if (coeff !== want_c) report_mismatch("coeff_out", {2'b0, coeff}, {2'b0, want_c});
                if (status !== want_s) report_mismatch("status", {62'b0, status}, {62'b0, want_s});
            end
        endtask

        function int pending();
            return exp_coeff.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 300000;

    logic          i_clk, i_rst_n, start, busy, o_done, i_cfg_we;
    logic [1:0]    i_op, o_status;
    logic [IW-1:0] i_index;
    logic [CW-1:0] i_coeff_in, o_coeff_out, i_cfg_data;
    logic [2:0]    i_cfg_index;

    ntt_scoreboard sb;
    bit            written [MAX_DEGREE];
    int            idle_cycles;
    int            requests;
    int            burst_left;

    negacyclic_ntt_engine_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_index(i_index), .i_coeff_in(i_coeff_in),
        .o_done(o_done), .o_coeff_out(o_coeff_out), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_coeff_out, o_status);
        if (!i_rst_n || o_done || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    function logic [CW-1:0] rand_coeff();
        return CW'({$urandom, $urandom});
    endfunction

    function logic [CW-1:0] rand_below_q();
        return CW'({2'b0, rand_coeff()} % sb.eff_q());
    endfunction

    task send(t_op op, int idx, logic [CW-1:0] val);
        bit taken;
        start = 1; i_op = op; i_index = IW'(idx); i_coeff_in = val;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            if (taken) sb.note_request(op, IW'(idx), val);
        end
        @(negedge i_clk);
        requests++;
        if (op == OP_WRITE && idx < (1 << sb.eff_log()) && {2'b0, val} < sb.eff_q())
            written[idx] = 1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start = 0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
    endtask

    task drain();
        start = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task cfg_write(logic [2:0] idx, logic [CW-1:0] data);
        i_cfg_we = 1; i_cfg_index = idx; i_cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task set_config(logic [CW-1:0] q, logic [3:0] lg, logic [CW-1:0] p,
                    logic [CW-1:0] pi, logic [CW-1:0] ni);
        drain();
        cfg_write(REG_MODULUS, q);
        cfg_write(REG_LOG, {58'b0, lg});
        cfg_write(REG_PSI, p);
        cfg_write(REG_PSI_INV, pi);
        cfg_write(REG_N_INV, ni);
    endtask

    task fill_active();
        for (int i = 0; i < (1 << sb.eff_log()); i++)
            if (!written[i]) send(OP_WRITE, i, rand_below_q());
    endtask

    task random_request();
        int n, r, idx;
        n = 1 << sb.eff_log();
        r = $urandom_range(0, 99);
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DEGREE - 1)
                                           : $urandom_range(0, n - 1);
        if (r < 10) send(OP_FWD, $urandom_range(0, MAX_DEGREE - 1), rand_coeff());
        else if (r < 20) send(OP_INV, $urandom_range(0, MAX_DEGREE - 1), rand_coeff());
        else if (r < 60)
            send(OP_WRITE, idx, ($urandom_range(0, 4) == 0) ? rand_coeff() : rand_below_q());
        else send(OP_READ, idx, rand_coeff());
    endtask

    initial begin
        logic [CW-1:0] q;
        sb = new();
        i_rst_n = 0; start = 0; i_op = OP_WRITE; i_index = '0; i_coeff_in = '0;
        i_cfg_we = 0; i_cfg_index = REG_MODULUS; i_cfg_data = '0;
        idle_cycles = 0; requests = 0; burst_left = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Reset settings: modulus 3 and full degree.
        send(OP_WRITE, MAX_DEGREE - 1, 2);
        send(OP_WRITE, 0, 3);
        send(OP_WRITE, 0, 0);
        send(OP_WRITE, 5, {CW{1'b1}});
        send(OP_READ, MAX_DEGREE - 1, 0);
        send(OP_READ, 0, {CW{1'b1}});

        // Modulus below three and degree zero fall back to 3 and n = 2.
        set_config(0, 0, 0, {CW{1'b1}}, 2);
        send(OP_WRITE, 1, 1);
        send(OP_WRITE, 2, {CW{1'b1}});
        send(OP_FWD, 0, 0);
        send(OP_READ, 0, 0);
        send(OP_READ, 1, 0);
        send(OP_INV, 0, 0);
        send(OP_READ, 1, 0);

        // Widest modulus and a degree setting that saturates.
        set_config({CW{1'b1}}, 4'd15, rand_coeff(), rand_coeff(), rand_coeff());
        send(OP_WRITE, 1023, {CW{1'b1}} - 1);
        send(OP_WRITE, 682, {CW{1'b1}});
        send(OP_WRITE, 341, 62'h2AAAAAAAAAAAAAAA);
        send(OP_READ, 1023, 0);
        send(OP_READ, 341, 0);

        // Stored values above a new, smaller modulus must be reduced by the transforms.
        set_config({CW{1'b1}}, 2, 0, 0, 0);
        for (int i = 0; i < 4; i++) send(OP_WRITE, i, rand_coeff() | (62'h1 << 61));
        set_config(CW'($urandom) | 62'h1_0000_0001, 2, rand_coeff(), rand_coeff(), rand_coeff());
        send(OP_FWD, 0, 0);
        send(OP_READ, 3, 0);
        send(OP_INV, 0, 0);
        send(OP_READ, 2, 0);

        for (int ph = 0; ph < 5; ph++) begin
            case ($urandom_range(0, 2))
                0: q = CW'($urandom_range(3, 1000));
                1: q = CW'({$urandom, $urandom} >> $urandom_range(2, 40));
                default: q = rand_coeff();
            endcase
            set_config(q, $urandom_range(1, 5), rand_coeff(), rand_coeff(), rand_coeff());
            fill_active();
            repeat (12) random_request();
        end

        drain();
        repeat (50) @(negedge i_clk);
        $display("Sent %0d requests, checked %0d results including %0d transforms.",
                 requests, sb.checked, sb.transforms);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
